// ===== rtl/core/lit_pkg.sv =====
// Shared constants, codes and pipeline types for the interpolating lookup table.
`timescale 1ns / 1ps
package lit_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int N_STAGES    = 6;

    localparam int DATA_W  = 32;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;
    localparam int FRAC_W  = 16;

    localparam logic [DATA_W-1:0]  INV_SPACING_RESET = 32'h0001_0000;
    localparam logic [COUNT_W-1:0] ENTRIES_RESET     = 11'd0;

    // action field codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // register select, taken from paddr[2]
    localparam logic REG_INV_SPACING = 1'b0;
    localparam logic REG_ENTRIES     = 1'b1;

    // per-stage advance and valid, bit k is stage k+1
    typedef struct packed {
        logic [N_STAGES-1:0] adv;
        logic [N_STAGES-1:0] vld;
    } t_pipe_ctl;

    // stage 2: segment index and fraction, or a pending table write
    typedef struct packed {
        logic                     query;
        logic [DATA_W-1:0]        seg;
        logic [FRAC_W-1:0]        frac;
        logic                     in_range;
        logic [INDEX_W-1:0]       wr_idx;
        logic signed [DATA_W-1:0] wr_val;
    } t_addr_stage;

    // stage 3: both segment end points read back from the table
    typedef struct packed {
        logic signed [DATA_W-1:0] y0;
        logic signed [DATA_W-1:0] y1;
        logic [FRAC_W-1:0]        frac;
        logic                     in_range;
    } t_read_stage;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] res;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            res = -32'sh8000_0000;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/linear_interp_table_lookup_top.sv =====
// Top level: handshake, valid chain, configuration registers and datapath stages.
// A query result passes through the input, address, memory, difference, product and result stages before it is shown.
// Throughput: one transaction per cycle unless the receiver stalls; stages advance independently so bubbles close up.
// A table write takes effect at the memory stage, after the input and address registers, in item order.
// Reset (synchronous, active low) clears all valid bits and sets inverse_spacing to 1.0
// and entries_in_use to 0; the sample table is not cleared.
`timescale 1ns / 1ps
module linear_interp_table_lookup_top #(
    parameter int TABLE_DEPTH = lit_pkg::TABLE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_action,
    input  logic [lit_pkg::INDEX_W-1:0]        i_entry_index,
    input  logic signed [lit_pkg::DATA_W-1:0]  i_entry_value,
    input  logic [lit_pkg::DATA_W-1:0]         i_position,

    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [lit_pkg::DATA_W-1:0]  o_value,
    output logic signed [lit_pkg::DATA_W-1:0]  o_slope,
    output logic                               o_in_range,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int NS = lit_pkg::N_STAGES;

    logic [NS-1:0]                  r_vld;
    logic [NS-1:0]                  adv;
    lit_pkg::t_pipe_ctl             ctl;
    lit_pkg::t_addr_stage           s2;
    lit_pkg::t_read_stage           s3;

    logic [lit_pkg::DATA_W-1:0]     r_inv_spacing;
    logic [lit_pkg::COUNT_W-1:0]    r_entries;
    logic                           cfg_wr;

    // a stage advances when it is empty or its successor advances
    always_comb begin
        adv[NS-1] = !r_vld[NS-1] || !i_stall;
        for (int k = NS-2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign ctl.adv = adv;
    assign ctl.vld = r_vld;
    assign o_stall = !adv[0];
    assign o_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            if (adv[1]) begin
                r_vld[1] <= r_vld[0];
            end
            // drop table writes once they reach the memory
            if (adv[2]) begin
                r_vld[2] <= r_vld[1] && s2.query;
            end
            for (int k = 3; k < NS; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_spacing <= lit_pkg::INV_SPACING_RESET;
            r_entries     <= lit_pkg::ENTRIES_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                lit_pkg::REG_INV_SPACING: r_inv_spacing <= pwdata;
                lit_pkg::REG_ENTRIES:     r_entries     <= pwdata[lit_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            lit_pkg::REG_INV_SPACING: prdata = r_inv_spacing;
            lit_pkg::REG_ENTRIES:     prdata = 32'(r_entries);
            default:                  prdata = '0;
        endcase
    end

    lit_addr_gen #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_addr_gen (
        .i_clk         (i_clk),
        .i_ctl         (ctl),
        .i_action      (i_action),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_position    (i_position),
        .i_inv_spacing (r_inv_spacing),
        .i_entries     (r_entries),
        .o_stage       (s2)
    );

    lit_sample_mem #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_sample_mem (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_stage (s2),
        .o_stage (s3)
    );

    lit_interp u_interp (
        .i_clk         (i_clk),
        .i_ctl         (ctl),
        .i_stage       (s3),
        .i_inv_spacing (r_inv_spacing),
        .o_value       (o_value),
        .o_slope       (o_slope),
        .o_in_range    (o_in_range)
    );

endmodule

// ===== rtl/core/lit_addr_gen.sv =====
// Stages 1 and 2: input register, position scaling and segment range check.
`timescale 1ns / 1ps
module lit_addr_gen #(
    parameter int TABLE_DEPTH = lit_pkg::TABLE_DEPTH
) (
    input  logic                                    i_clk,
    input  lit_pkg::t_pipe_ctl                      i_ctl,
    input  logic                                    i_action,
    input  logic [lit_pkg::INDEX_W-1:0]             i_entry_index,
    input  logic signed [lit_pkg::DATA_W-1:0]       i_entry_value,
    input  logic [lit_pkg::DATA_W-1:0]              i_position,
    input  logic [lit_pkg::DATA_W-1:0]              i_inv_spacing,
    input  logic [lit_pkg::COUNT_W-1:0]             i_entries,
    output lit_pkg::t_addr_stage                    o_stage
);

    logic                               r1_action;
    logic [lit_pkg::INDEX_W-1:0]        r1_idx;
    logic signed [lit_pkg::DATA_W-1:0]  r1_val;
    logic [lit_pkg::DATA_W-1:0]         r1_pos;

    logic                               r2_query;
    logic [lit_pkg::DATA_W-1:0]         r2_seg;
    logic [lit_pkg::FRAC_W-1:0]         r2_frac;
    logic [lit_pkg::INDEX_W-1:0]        r2_idx;
    logic signed [lit_pkg::DATA_W-1:0]  r2_val;

    logic [2*lit_pkg::DATA_W-1:0]       prod;
    logic [lit_pkg::DATA_W:0]           cnt_req;
    logic [lit_pkg::DATA_W:0]           cnt_eff;

    // Q16.16 times Q16.16 gives Q32.32: integer part is the segment
    assign prod = 64'(r1_pos) * 64'(i_inv_spacing);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[0]) begin
            r1_action <= i_action;
            r1_idx    <= i_entry_index;
            r1_val    <= i_entry_value;
            r1_pos    <= i_position;
        end
        if (i_ctl.adv[1]) begin
            r2_query <= (r1_action == lit_pkg::ACT_QUERY);
            r2_seg   <= prod[2*lit_pkg::DATA_W-1:lit_pkg::DATA_W];
            r2_frac  <= prod[lit_pkg::DATA_W-1:lit_pkg::DATA_W-lit_pkg::FRAC_W];
            r2_idx   <= r1_idx;
            r2_val   <= r1_val;
        end
    end

    // clamp the entry count to the table depth
    assign cnt_req = (lit_pkg::DATA_W+1)'(i_entries);
    assign cnt_eff = (cnt_req > (lit_pkg::DATA_W+1)'(TABLE_DEPTH)) ?
                     (lit_pkg::DATA_W+1)'(TABLE_DEPTH) : cnt_req;

    always_comb begin
        o_stage          = '0;
        o_stage.query    = r2_query;
        o_stage.seg      = r2_seg;
        o_stage.frac     = r2_frac;
        o_stage.in_range = (((lit_pkg::DATA_W+1)'(r2_seg) + 33'd1) < cnt_eff);
        o_stage.wr_idx   = r2_idx;
        o_stage.wr_val   = r2_val;
    end

endmodule

// ===== rtl/core/lit_sample_mem.sv =====
// Stage 3: sample table with one write port and two registered read ports.
`timescale 1ns / 1ps
module lit_sample_mem #(
    parameter int TABLE_DEPTH = lit_pkg::TABLE_DEPTH
) (
    input  logic                  i_clk,
    input  lit_pkg::t_pipe_ctl    i_ctl,
    input  lit_pkg::t_addr_stage  i_stage,
    output lit_pkg::t_read_stage  o_stage
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic signed [lit_pkg::DATA_W-1:0] mem [TABLE_DEPTH];

    logic signed [lit_pkg::DATA_W-1:0] r3_y0;
    logic signed [lit_pkg::DATA_W-1:0] r3_y1;
    logic [lit_pkg::FRAC_W-1:0]        r3_frac;
    logic                              r3_in_range;

    logic [AW-1:0] rd_addr0;
    logic [AW-1:0] rd_addr1;
    logic [AW-1:0] wr_addr;
    logic          wr_en;

    assign rd_addr0 = AW'(i_stage.seg);
    assign rd_addr1 = AW'(i_stage.seg + 32'd1);
    assign wr_addr  = AW'(i_stage.wr_idx);

    // writes land in the same stage as reads, so item order is kept
    assign wr_en = i_ctl.vld[1] && i_ctl.adv[2] && !i_stage.query &&
                   (32'(i_stage.wr_idx) < 32'(TABLE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_stage.wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[2]) begin
            r3_y0       <= mem[rd_addr0];
            r3_y1       <= mem[rd_addr1];
            r3_frac     <= i_stage.frac;
            r3_in_range <= i_stage.in_range;
        end
    end

    always_comb begin
        o_stage.y0       = r3_y0;
        o_stage.y1       = r3_y1;
        o_stage.frac     = r3_frac;
        o_stage.in_range = r3_in_range;
    end

endmodule

// ===== rtl/core/lit_interp.sv =====
// Stages 4 to 6: difference, products, shift, saturation and result register.
`timescale 1ns / 1ps
module lit_interp (
    input  logic                               i_clk,
    input  lit_pkg::t_pipe_ctl                 i_ctl,
    input  lit_pkg::t_read_stage               i_stage,
    input  logic [lit_pkg::DATA_W-1:0]         i_inv_spacing,
    output logic signed [lit_pkg::DATA_W-1:0]  o_value,
    output logic signed [lit_pkg::DATA_W-1:0]  o_slope,
    output logic                               o_in_range
);

    logic signed [lit_pkg::DATA_W:0]    r4_d;
    logic signed [lit_pkg::DATA_W-1:0]  r4_y0;
    logic [lit_pkg::FRAC_W-1:0]         r4_frac;
    logic                               r4_in_range;

    logic signed [49:0]                 r5_pv;
    logic signed [65:0]                 r5_ps;
    logic signed [lit_pkg::DATA_W-1:0]  r5_y0;
    logic                               r5_in_range;

    logic signed [lit_pkg::DATA_W-1:0]  r_value;
    logic signed [lit_pkg::DATA_W-1:0]  r_slope;
    logic                               r_in_range;

    logic signed [lit_pkg::DATA_W:0]    d_next;
    logic signed [49:0]                 pv_next;
    logic signed [65:0]                 ps_next;
    logic signed [63:0]                 val_wide;
    logic signed [63:0]                 slp_wide;

    assign d_next  = (lit_pkg::DATA_W+1)'(i_stage.y1) - (lit_pkg::DATA_W+1)'(i_stage.y0);
    assign pv_next = r4_d * signed'({1'b0, r4_frac});
    assign ps_next = r4_d * signed'({1'b0, i_inv_spacing});

    // arithmetic shift floors toward minus infinity
    assign val_wide = 64'(r5_y0) + 64'(r5_pv >>> lit_pkg::FRAC_W);
    assign slp_wide = 64'(r5_ps >>> lit_pkg::FRAC_W);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[3]) begin
            r4_d        <= d_next;
            r4_y0       <= i_stage.y0;
            r4_frac     <= i_stage.frac;
            r4_in_range <= i_stage.in_range;
        end
        if (i_ctl.adv[4]) begin
            r5_pv       <= pv_next;
            r5_ps       <= ps_next;
            r5_y0       <= r4_y0;
            r5_in_range <= r4_in_range;
        end
        if (i_ctl.adv[5]) begin
            r_in_range <= r5_in_range;
            if (r5_in_range) begin
                r_value <= lit_pkg::sat32(val_wide);
                r_slope <= lit_pkg::sat32(slp_wide);
            end else begin
                r_value <= '0;
                r_slope <= '0;
            end
        end
    end

    assign o_value    = r_value;
    assign o_slope    = r_slope;
    assign o_in_range = r_in_range;

endmodule

// ===== rtl/core/lit_checker.sv =====
// Port-level checks for the interpolating lookup table, bound to the top level.
`timescale 1ns / 1ps
module lit_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic signed [lit_pkg::DATA_W-1:0]  o_value,
    input logic signed [lit_pkg::DATA_W-1:0]  o_slope,
    input logic                               o_in_range,
    input logic                               pready
);

    // out-of-range results carry zero value and slope
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_range) |-> (o_value == '0 && o_slope == '0))
        else $error("out-of-range result with non-zero fields");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // configuration port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_value) && $stable(o_slope)
                                  && $stable(o_in_range)))
        else $error("stalled result changed");

    // a result leaves only through a completed transaction
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_valid) |-> $past(!i_stall))
        else $error("result dropped without transaction");

endmodule

bind linear_interp_table_lookup_top lit_checker u_lit_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_value    (o_value),
    .o_slope    (o_slope),
    .o_in_range (o_in_range),
    .pready     (pready)
);

// ===== bench/testbench.sv =====
// Self-checking testbench for the interpolating lookup table: directed rows then random phases.
`timescale 1ns / 1ps
module testbench;
    import lit_pkg::*;

    localparam int SETTLE     = N_STAGES + 4;
    localparam int HOLD_LEN   = 60;
    localparam int N_PHASES   = 8;
    localparam int PHASE_LEN  = 82;
    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] slope;
        logic                     in_range;
    } lut_result_t;

    localparam lut_result_t NO_RESULT = '{value: '0, slope: '0, in_range: 1'b0};

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e                kind;
        logic                     action;
        logic [INDEX_W-1:0]       idx;
        logic signed [DATA_W-1:0] sample;
        logic [DATA_W-1:0]        pos;
        logic                     cfg_reg;
        logic [31:0]              cfg_val;
        bit                       typed;
        lut_result_t              want;
    } stim_row_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic                      i_action;
    logic [INDEX_W-1:0]        i_entry_index;
    logic signed [DATA_W-1:0]  i_entry_value;
    logic [DATA_W-1:0]         i_position;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic signed [DATA_W-1:0]  o_value;
    logic signed [DATA_W-1:0]  o_slope;
    logic                      o_in_range;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [2:0]                paddr;
    logic [31:0]               pwdata;
    logic [31:0]               prdata;
    logic                      pready;

    // predictor state
    logic [DATA_W-1:0]  sample_mem [TABLE_DEPTH];
    bit                 sample_written [TABLE_DEPTH];
    int                 written_prefix = 0;
    logic [DATA_W-1:0]  inv_spacing_q = INV_SPACING_RESET;
    logic [COUNT_W-1:0] entries_q     = ENTRIES_RESET;

    lut_result_t pending_results[$];
    lut_result_t head_result;
    int          mismatches = 0;
    int          idle_pct   = 0;
    int          stall_pct  = 0;
    int          hold_req   = 0;
    int          hold_seen  = 0;
    int          hold_left  = 0;
    stim_row_t   dir_rows[$];

    linear_interp_table_lookup_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_position    (i_position),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_value       (o_value),
        .o_slope       (o_slope),
        .o_in_range    (o_in_range),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic int active_entries();
        return (entries_q > TABLE_DEPTH) ? TABLE_DEPTH : int'(entries_q);
    endfunction

    function automatic logic [63:0] scaled_position(input logic [DATA_W-1:0] pos);
        return {32'd0, pos} * {32'd0, inv_spacing_q};
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp32(input logic signed [71:0] v);
        if (v > 72'sh7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -72'sh8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[DATA_W-1:0];
    endfunction

    // segment is outside the table, or both of its end points hold written samples
    function automatic bit query_is_defined(input logic [DATA_W-1:0] pos);
        logic [63:0] prod;
        logic [63:0] seg;
        prod = scaled_position(pos);
        seg  = {32'd0, prod[63:32]};
        if (seg + 1 >= 64'(active_entries())) begin
            return 1'b1;
        end
        return sample_written[seg[INDEX_W-1:0]] && sample_written[seg[INDEX_W-1:0] + 1'b1];
    endfunction

    function automatic lut_result_t interp_lookup(input logic [DATA_W-1:0] pos);
        logic [63:0]        prod;
        logic [63:0]        seg;
        logic [FRAC_W-1:0]  frac;
        logic signed [71:0] y0;
        logic signed [71:0] y1;
        logic signed [71:0] diff;
        lut_result_t        res;
        prod = scaled_position(pos);
        seg  = {32'd0, prod[63:32]};
        frac = prod[31:16];
        res  = NO_RESULT;
        if (seg + 1 < 64'(active_entries())) begin
            y0   = $signed(sample_mem[seg[INDEX_W-1:0]]);
            y1   = $signed(sample_mem[seg[INDEX_W-1:0] + 1'b1]);
            diff = y1 - y0;
            // arithmetic shift of the product rounds toward minus infinity
            res.value    = clamp32(y0 + ((diff * $signed({56'd0, frac})) >>> 16));
            res.slope    = clamp32((diff * $signed({40'd0, inv_spacing_q})) >>> 16);
            res.in_range = 1'b1;
        end
        return res;
    endfunction

    function automatic void store_sample(input logic [INDEX_W-1:0] idx,
                                         input logic [DATA_W-1:0] val);
        sample_mem[idx]     = val;
        sample_written[idx] = 1'b1;
        while (written_prefix < TABLE_DEPTH && sample_written[written_prefix]) begin
            written_prefix++;
        end
    endfunction

    // position whose segment is at most seg
    function automatic logic [DATA_W-1:0] aim_at(input int unsigned seg);
        logic [63:0] goal;
        logic [63:0] quo;
        if (inv_spacing_q == '0) begin
            return $urandom;
        end
        goal = {seg, $urandom};
        quo  = goal / {32'd0, inv_spacing_q};
        return (quo > 64'hFFFF_FFFF) ? '1 : quo[31:0];
    endfunction

    function automatic logic [DATA_W-1:0] pick_position();
        int               cls;
        int               hi;
        int               edge_seg;
        logic [DATA_W-1:0] pos;
        hi  = (active_entries() < written_prefix) ? active_entries() : written_prefix;
        cls = $urandom_range(0, 99);
        if (cls < 25) begin
            pos = $urandom;
        end else if (cls < 40) begin
            edge_seg = active_entries() - 1 + $urandom_range(0, 1);
            pos = aim_at((edge_seg < 0) ? 0 : edge_seg);
        end else begin
            pos = aim_at((hi >= 2) ? $urandom_range(0, hi - 2) : 0);
        end
        // fall back to a segment inside the written prefix
        if (!query_is_defined(pos)) begin
            pos = aim_at($urandom_range(0, hi - 2));
        end
        return pos;
    endfunction

    function automatic stim_row_t wr_row(input logic [INDEX_W-1:0] idx,
                                         input logic [DATA_W-1:0] val);
        stim_row_t row;
        row = '{kind: ROW_ITEM, action: ACT_WRITE, idx: idx, sample: val, pos: $urandom,
                cfg_reg: REG_INV_SPACING, cfg_val: '0, typed: 1'b0, want: NO_RESULT};
        return row;
    endfunction

    function automatic stim_row_t q_row(input logic [DATA_W-1:0] pos);
        stim_row_t row;
        row = '{kind: ROW_ITEM, action: ACT_QUERY, idx: INDEX_W'($urandom), sample: $urandom,
                pos: pos, cfg_reg: REG_INV_SPACING, cfg_val: '0, typed: 1'b0,
                want: NO_RESULT};
        return row;
    endfunction

    function automatic stim_row_t q_typed(input logic [DATA_W-1:0] pos, input lut_result_t want);
        stim_row_t row;
        row       = q_row(pos);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(input logic reg_sel, input logic [31:0] val);
        stim_row_t row;
        row = '{kind: ROW_CFG, action: ACT_WRITE, idx: '0, sample: '0, pos: '0,
                cfg_reg: reg_sel, cfg_val: val, typed: 1'b0, want: NO_RESULT};
        return row;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("%0t ns: %s mismatch: got %h, want %h", $time, what, got, want);
        end
    endtask

    task automatic write_register(input logic reg_sel, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_INV_SPACING) begin
            inv_spacing_q = val;
        end else begin
            entries_q = val[COUNT_W-1:0];
        end
    endtask

    task automatic drain_results(input int extra);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic send_item(input stim_row_t row);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= row.action;
        i_entry_index <= row.idx;
        i_entry_value <= row.sample;
        i_position    <= row.pos;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (row.action == ACT_WRITE) begin
            store_sample(row.idx, row.sample);
        end else begin
            pending_results.push_back(row.typed ? row.want : interp_lookup(row.pos));
        end
    endtask

    // receiver: random stall, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_LEN;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction", o_value, '0);
            end else begin
                head_result = pending_results.pop_front();
                if (o_value !== head_result.value) begin
                    report_mismatch("value", o_value, head_result.value);
                end
                if (o_slope !== head_result.slope) begin
                    report_mismatch("slope", o_slope, head_result.slope);
                end
                if (o_in_range !== head_result.in_range) begin
                    report_mismatch("in_range", 32'(o_in_range), 32'(head_result.in_range));
                end
            end
        end
    end

    initial begin
        #3_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        stim_row_t         row;
        int                sel;
        int                upper;
        logic [31:0]       val;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_action      <= ACT_WRITE;
        i_entry_index <= '0;
        i_entry_value <= '0;
        i_position    <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;

        // empty table: every query falls outside it
        dir_rows.push_back(q_typed(32'h0000_0000, NO_RESULT));
        dir_rows.push_back(q_typed(32'hFFFF_FFFF, NO_RESULT));
        dir_rows.push_back(wr_row(10'd0, 32'h8000_0000));
        dir_rows.push_back(wr_row(10'd1, 32'h7FFF_FFFF));
        dir_rows.push_back(wr_row(10'd2, 32'h0000_0000));
        dir_rows.push_back(wr_row(10'd3, 32'hFFFF_FFFF));
        dir_rows.push_back(wr_row(10'd4, 32'h0001_0000));
        dir_rows.push_back(wr_row(10'd5, 32'h0003_0000));
        dir_rows.push_back(wr_row(10'd6, 32'h7FFF_FFFF));
        dir_rows.push_back(wr_row(10'd7, 32'h8000_0000));
        dir_rows.push_back(wr_row(10'd1022, 32'hA5A5_A5A5));
        dir_rows.push_back(wr_row(10'd1023, 32'h5A5A_5A5A));
        dir_rows.push_back(cfg_row(REG_ENTRIES, 32'd8));
        dir_rows.push_back(q_row(32'h0000_0000));
        dir_rows.push_back(q_row(32'h0000_8000));
        dir_rows.push_back(q_row(32'h0002_C000));
        dir_rows.push_back(q_row(32'h0006_FFFF));
        dir_rows.push_back(q_typed(32'h0007_0000, NO_RESULT));
        // widest spacing reciprocal; entry count beyond the depth clips to it
        dir_rows.push_back(cfg_row(REG_INV_SPACING, 32'hFFFF_FFFF));
        dir_rows.push_back(cfg_row(REG_ENTRIES, 32'd2047));
        dir_rows.push_back(q_row(32'h0000_0001));
        dir_rows.push_back(q_row(32'h0000_0006));
        dir_rows.push_back(q_row(32'h0000_0007));
        dir_rows.push_back(q_typed(32'hFFFF_FFFF, NO_RESULT));
        // zero reciprocal pins every query to the first sample
        dir_rows.push_back(cfg_row(REG_INV_SPACING, 32'h0000_0000));
        dir_rows.push_back(q_typed(32'h1234_5678,
            '{value: 32'sh8000_0000, slope: '0, in_range: 1'b1}));
        dir_rows.push_back(cfg_row(REG_ENTRIES, 32'd1));
        dir_rows.push_back(cfg_row(REG_INV_SPACING, 32'h0001_0000));
        dir_rows.push_back(q_typed(32'h0000_0000, NO_RESULT));
        dir_rows.push_back(cfg_row(REG_ENTRIES, 32'd1024));
        dir_rows.push_back(q_row(32'h03FE_8000));
        dir_rows.push_back(q_typed(32'h03FF_0000, NO_RESULT));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                drain_results(SETTLE);
                write_register(dir_rows[i].cfg_reg, dir_rows[i].cfg_val);
            end else begin
                send_item(dir_rows[i]);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 59; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 59; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            drain_results(SETTLE);
            sel = $urandom_range(0, 9);
            case (sel)
                0: val = 32'h0001_0000;
                1: val = 32'hFFFF_FFFF;
                2: val = $urandom;
                default: val = $urandom_range(1 << 13, 1 << 19);
            endcase
            write_register(REG_INV_SPACING, val);
            sel   = $urandom_range(0, 9);
            upper = (written_prefix + 3 > 1030) ? 1030 : written_prefix + 3;
            case (sel)
                0: val = $urandom_range(0, 2047);
                1: val = 32'd1024;
                default: val = $urandom_range(2, upper);
            endcase
            write_register(REG_ENTRIES, val);

            for (int k = 0; k < PHASE_LEN; k++) begin
                if (ph == 4 && k == 10) begin
                    hold_req++;
                end
                // hold the sender until every expected transaction is back
                if (ph == 2 && k == 40) begin
                    drain_results(0);
                end
                if ($urandom_range(0, 99) < 30) begin
                    sel = $urandom_range(0, 9);
                    if (sel < 4 && written_prefix < TABLE_DEPTH) begin
                        row = wr_row(INDEX_W'(written_prefix), '0);
                    end else if (sel < 7) begin
                        row = wr_row(INDEX_W'($urandom_range(0, written_prefix - 1)), '0);
                    end else begin
                        row = wr_row(INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)), '0);
                    end
                    sel = $urandom_range(0, 9);
                    case (sel)
                        0: begin
                            case ($urandom_range(0, 3))
                                0: row.sample = 32'sh8000_0000;
                                1: row.sample = 32'sh7FFF_FFFF;
                                2: row.sample = '0;
                                default: row.sample = '1;
                            endcase
                        end
                        1, 2, 3, 4, 5: row.sample = $urandom_range(0, 1 << 21) - (1 << 20);
                        default: row.sample = $urandom;
                    endcase
                end else begin
                    row = q_row(pick_position());
                end
                send_item(row);
            end
        end

        drain_results(SETTLE);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
